FILE: rtl/core/cdte_pkg.sv
// shared types, constants and helper functions for the date to epoch seconds converter
package cdte_pkg;

  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned EpochW  = 32;
  localparam int unsigned DaysW   = 21;
  localparam int unsigned HmsW    = 17;
  localparam int unsigned InDataW = 40;

  localparam logic [YearW-1:0]   BaseYear        = 12'd1970;
  localparam logic [9:0]         LeapsBeforeBase = 10'd477;
  localparam logic [OffsetW-1:0] OffsetReset     = 17'd3600;
  localparam logic [MonthW-1:0]  MonthFullYear   = 4'd12;
  localparam logic [MonthW-1:0]  MonthMarch      = 4'd2;

  typedef struct packed {
    logic [SecondW-1:0] second;
    logic [MinuteW-1:0] minute;
    logic [HourW-1:0]   hour;
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
  } cdte_in_t;

  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [HmsW-1:0]  hms;
  } cdte_mid_t;

  // days before the first of each month in a common year, last entry is a full year
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] k);
    logic [8:0] r;
    case (k)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

  // floor(z / 25) for z below 1024, by reciprocal multiply
  function automatic logic [5:0] div25(input logic [9:0] z);
    logic [20:0] p;
    p = 21'(z) * 21'd1311;
    return p[20:15];
  endfunction

  // true when z is a multiple of 25
  function automatic logic mult25(input logic [9:0] z);
    logic [5:0] q;
    logic [9:0] back;
    q    = div25(z);
    back = {q, 4'b0} + {1'b0, q, 3'b0} + {4'b0, q};
    return back == z;
  endfunction

  // leap years in 1..y
  function automatic logic [9:0] leaps_through(input logic [YearW-1:0] y);
    logic [10:0] s;
    s = 11'(y[11:2]) - 11'(div25(y[11:2])) + 11'(div25({2'b0, y[11:4]}));
    return s[9:0];
  endfunction

endpackage

FILE: rtl/core/cdte_day_count.sv
// first stage: day count since the base date and seconds within the day
module cdte_day_count
  import cdte_pkg::*;
(
  input  cdte_in_t  cal_i,
  output cdte_mid_t mid_o
);

  logic [YearW-1:0]  ydiff;
  logic [19:0]       days_year;
  logic [MonthW-1:0] k;
  logic              is_leap;
  logic              leap_day;
  logic [DaysW-1:0]  days_sum;
  logic [HmsW-1:0]   hms;

  always_comb begin
    ydiff = cal_i.year - BaseYear;
    if (cal_i.year > BaseYear) begin
      days_year = 20'(ydiff) * 20'd365 + 20'(leaps_through(cal_i.year - 12'd1))
                - 20'(LeapsBeforeBase);
    end else begin
      days_year = '0;
    end

    if (cal_i.month == '0) begin
      k = '0;
    end else if (cal_i.month > MonthFullYear) begin
      k = MonthFullYear;
    end else begin
      k = cal_i.month - 4'd1;
    end

    is_leap = ((cal_i.year[1:0] == 2'b00) && !mult25(cal_i.year[11:2]))
            || ((cal_i.year[3:0] == 4'b0000) && mult25({2'b0, cal_i.year[11:4]}));
    leap_day = (k >= MonthMarch) && is_leap;

    days_sum = 21'(days_year) + 21'(month_start(k)) + 21'(leap_day)
             + 21'(cal_i.day) - 21'd1;

    hms = 17'(cal_i.hour) * 17'd3600 + 17'(cal_i.minute) * 17'd60 + 17'(cal_i.second);

    mid_o.days = days_sum;
    mid_o.hms  = hms;
  end

endmodule

FILE: rtl/core/cdte_sec_sum.sv
// second stage: days to seconds, add time of day, subtract the offset
module cdte_sec_sum
  import cdte_pkg::*;
(
  input  cdte_mid_t           mid_i,
  input  logic [OffsetW-1:0]  offset_i,
  output logic [EpochW-1:0]   secs_o
);

  logic [EpochW-1:0] days_ext;
  logic [EpochW-1:0] off_ext;
  logic [EpochW-1:0] day_secs;

  always_comb begin
    days_ext = {{(EpochW-DaysW){mid_i.days[DaysW-1]}}, mid_i.days};
    off_ext  = {{(EpochW-OffsetW){offset_i[OffsetW-1]}}, offset_i};
    day_secs = days_ext * 32'd86400;
    secs_o   = day_secs + 32'(mid_i.hms) - off_ext;
  end

endmodule

FILE: rtl/core/civil_date_to_epoch_seconds.sv
// top level: calendar date and time of day to seconds since 1970-01-01 minus an offset
// Converts one date word per clock cycle into a 32-bit count of seconds since
// 1970-01-01 00:00:00 under the Gregorian leap rule, minus the signed offset held
// in the configuration register (reset 3600). Day and time fields have no range
// check; month 0 counts as January, a month above 12 adds a full year of days, a
// year before 1970 adds no year days, and the result wraps modulo 2^32. The path is
// three registers deep (input register, day count register, result register), and
// the result register drives the output; one word is taken every cycle as long as
// the output side keeps up, and a stall at the output holds each stage in turn.
// Write the offset only while no word is in flight.
module civil_date_to_epoch_seconds
  import cdte_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [OffsetW-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26], second[37:32]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // epoch_seconds[31:0]
  output logic [EpochW-1:0]   m_axis_tdata
);

  logic [OffsetW-1:0] offset_q;
  logic               in_v_q;
  cdte_in_t           in_q;
  logic               mid_v_q;
  cdte_mid_t          mid_q, mid_d;
  logic               out_v_q;
  logic [EpochW-1:0]  out_q, out_d;
  logic               out_rdy, mid_rdy;

  assign out_rdy       = !out_v_q || m_axis_tready;
  assign mid_rdy       = !mid_v_q || out_rdy;
  assign s_axis_tready = !in_v_q || mid_rdy;

  cdte_day_count u_day_count (
    .cal_i (in_q),
    .mid_o (mid_d)
  );

  cdte_sec_sum u_sec_sum (
    .mid_i    (mid_q),
    .offset_i (offset_q),
    .secs_o   (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
      in_v_q   <= 1'b0;
      mid_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (mid_rdy) begin
        mid_v_q <= in_v_q;
      end
      if (out_rdy) begin
        out_v_q <= mid_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= cdte_in_t'(s_axis_tdata[37:0]);
    end
    if (mid_rdy && in_v_q) begin
      mid_q <= mid_d;
    end
    if (out_rdy && mid_v_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule
